/* hw/rtl/bps_pkg.sv */
package bps_pkg;

  localparam int unsigned TIME_W          = 32;
  localparam int unsigned MS_W            = 16;
  localparam int unsigned SLOT_W          = 2;
  localparam int unsigned MAX_SLOTS       = 3;
  localparam int unsigned PULSE_SLOTS_DEF = 3;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_START = 1'b1
  } action_t;

  typedef struct packed {
    action_t         action;
    logic [MS_W-1:0] first_ms;
    logic [MS_W-1:0] second_ms;
    logic [MS_W-1:0] third_ms;
    logic [MS_W-1:0] gap_ms;
    logic [MS_W-1:0] end_ms;
  } item_t;

  typedef struct packed {
    logic sound_pin;
    logic busy_res;
  } res_t;

  // Core status, watched by the checks in the top level
  typedef struct packed {
    logic              active;
    logic              tone_on;
    logic              pin_level;
    logic [SLOT_W-1:0] slot;
  } stat_t;

endpackage

/* hw/rtl/beep_pattern_sequencer_top.sv */
// Path: an accepted request waits in the input register and moves on into the result
//   register once that register has room, longer only while the result side holds off.
// Throughput: one request per cycle while results are taken; the sequencer state
//   updates in combinational logic between the input register and the result register.
// Reset: rst_n is synchronous and active low; it clears time, sequence state and both
//   handshake stages. Pulse, gap and pause lengths are held only from the next start.
module beep_pattern_sequencer_top #(
  parameter int unsigned PULSE_SLOTS = bps_pkg::PULSE_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic [bps_pkg::MS_W-1:0] in_first_ms,
  input  logic [bps_pkg::MS_W-1:0] in_second_ms,
  input  logic [bps_pkg::MS_W-1:0] in_third_ms,
  input  logic [bps_pkg::MS_W-1:0] in_gap_ms,
  input  logic [bps_pkg::MS_W-1:0] in_end_ms,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_sound_pin,
  output logic                     out_busy_res
);

  bps_pkg::item_t item_in;
  bps_pkg::item_t item_held;
  bps_pkg::res_t  res_nxt;
  bps_pkg::res_t  res_out;
  bps_pkg::stat_t stat;
  logic           held_vld;
  logic           out_free;
  logic           fire;

  // Pack the incoming request fields
  assign item_in.action    = bps_pkg::action_t'(in_action);
  assign item_in.first_ms  = in_first_ms;
  assign item_in.second_ms = in_second_ms;
  assign item_in.third_ms  = in_third_ms;
  assign item_in.gap_ms    = in_gap_ms;
  assign item_in.end_ms    = in_end_ms;

  // Advance the held request into the result register whenever that register has room;
  // the sequencer state commits on the same edge.
  assign fire = held_vld && out_free;

  bps_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_i   (item_in),
    .valid_o  (held_vld),
    .item_o   (item_held),
    .take_i   (fire)
  );

  bps_core #(
    .PULSE_SLOTS (PULSE_SLOTS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire_i (fire),
    .item_i (item_held),
    .res_o  (res_nxt),
    .stat_o (stat)
  );

  bps_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (fire),
    .res_i     (res_nxt),
    .free_o    (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_o     (res_out)
  );

  assign out_sound_pin = res_out.sound_pin;
  assign out_busy_res  = res_out.busy_res;

`ifndef ASSERT_OFF
  // Slot index never runs past the end-pause slot
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.slot <= 2'(PULSE_SLOTS))
    else $error("slot index beyond end-pause slot");

  // Pin is high only while a pulse is on, and a pulse is on only during a sequence
  a_pin_tone: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pin_level |-> (stat.tone_on && stat.active))
    else $error("pin high outside an active pulse");

  // A request moved out of the input register always shows up as a result
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("result lost after advance");

  // The registered busy flag matches the sequencer state it was taken from
  a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_busy_res == stat.active))
    else $error("busy result disagrees with sequencer state");
`endif

endmodule

/* hw/rtl/bps_in_reg.sv */
module bps_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bps_pkg::item_t item_i,
  output logic           valid_o,
  output bps_pkg::item_t item_o,
  input  logic           take_i
);

  logic           vld_r;
  logic           vld_nxt;
  bps_pkg::item_t item_r;

  // Accept whenever the held request leaves in this cycle or none is held
  assign in_ready = !vld_r || take_i;
  assign vld_nxt  = in_valid || (vld_r && !take_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_i;
    end
  end

  assign valid_o = vld_r;
  assign item_o  = item_r;

endmodule

/* hw/rtl/bps_core.sv */
module bps_core #(
  parameter int unsigned PULSE_SLOTS = bps_pkg::PULSE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire_i,
  input  bps_pkg::item_t item_i,
  output bps_pkg::res_t  res_o,
  output bps_pkg::stat_t stat_o
);

  localparam int unsigned TW = bps_pkg::TIME_W;
  localparam int unsigned MW = bps_pkg::MS_W;
  localparam int unsigned SW = bps_pkg::SLOT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(PULSE_SLOTS);

  logic [TW-1:0] now_r, now_nxt;
  logic          act_r, act_nxt;
  logic          cd_r, cd_nxt;
  logic          ton_r, ton_nxt;
  logic          pin_r, pin_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [TW-1:0] last_r, last_nxt;

  logic [MW-1:0] pulse_r [PULSE_SLOTS];
  logic [MW-1:0] gap_r;
  logic [MW-1:0] end_r;

  logic [MW-1:0] in_pulse [bps_pkg::MAX_SLOTS];
  logic [MW-1:0] pulse_e  [PULSE_SLOTS];
  logic [MW-1:0] gap_e;
  logic [MW-1:0] end_e;
  logic [MW-1:0] psel;
  logic [MW-1:0] slot_val;
  logic          is_tick;
  logic          load;
  logic          in_pulse_slot;
  logic          ended;

  assign in_pulse[0] = item_i.first_ms;
  assign in_pulse[1] = item_i.second_ms;
  assign in_pulse[2] = item_i.third_ms;

  assign is_tick = (item_i.action == bps_pkg::ACT_TICK);
  // A start only loads while idle; a start while busy changes nothing
  assign load    = !is_tick && !act_r;
  assign now_nxt = is_tick ? now_r + TW'(1) : now_r;
  assign gap_e   = load ? item_i.gap_ms : gap_r;
  assign end_e   = load ? item_i.end_ms : end_r;

  always_comb begin
    for (int i = 0; i < PULSE_SLOTS; i++) begin
      pulse_e[i] = load ? in_pulse[i] : pulse_r[i];
    end
  end

  always_comb begin
    psel = '0;
    for (int i = 0; i < PULSE_SLOTS; i++) begin
      if (slot_r == SW'(i)) begin
        psel = pulse_e[i];
      end
    end
  end

  assign in_pulse_slot = (slot_r < LAST_SLOT);
  assign slot_val      = in_pulse_slot ? psel : end_e;

  always_comb begin
    act_nxt  = act_r || load;
    cd_nxt   = cd_r;
    ton_nxt  = ton_r;
    pin_nxt  = pin_r;
    slot_nxt = slot_r;
    last_nxt = last_r;
    ended    = 1'b0;
    if (is_tick || load) begin
      if (!act_nxt) begin
        if (ton_r) begin
          pin_nxt = 1'b0;
        end
      end else begin
        if (in_pulse_slot) begin
          if (psel != '0) begin
            if (!ton_r && (now_nxt >= last_r + TW'(gap_e))) begin
              ton_nxt  = 1'b1;
              pin_nxt  = 1'b1;
              last_nxt = now_nxt;
            end else if (ton_r && (now_nxt >= last_r + TW'(psel))) begin
              ton_nxt  = 1'b0;
              cd_nxt   = 1'b1;
              pin_nxt  = 1'b0;
              last_nxt = now_nxt;
            end
          end
        end else if (last_r < now_nxt - TW'(end_e)) begin
          // End pause has run out: drop back to idle
          ended    = 1'b1;
          slot_nxt = '0;
          act_nxt  = 1'b0;
          if (ton_r) begin
            pin_nxt = 1'b0;
          end
        end
        if (!ended && (cd_nxt || slot_val == '0)) begin
          if (in_pulse_slot) begin
            slot_nxt = slot_r + SW'(1);
          end
          cd_nxt = 1'b0;
          if (ton_nxt) begin
            pin_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      act_r  <= 1'b0;
      cd_r   <= 1'b0;
      ton_r  <= 1'b0;
      pin_r  <= 1'b0;
      slot_r <= '0;
      last_r <= '0;
    end else if (fire_i) begin
      now_r  <= now_nxt;
      act_r  <= act_nxt;
      cd_r   <= cd_nxt;
      ton_r  <= ton_nxt;
      pin_r  <= pin_nxt;
      slot_r <= slot_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_i && load) begin
      for (int i = 0; i < PULSE_SLOTS; i++) begin
        pulse_r[i] <= in_pulse[i];
      end
      gap_r <= item_i.gap_ms;
      end_r <= item_i.end_ms;
    end
  end

  assign res_o.sound_pin = pin_nxt;
  assign res_o.busy_res  = act_nxt;

  assign stat_o.active    = act_r;
  assign stat_o.tone_on   = ton_r;
  assign stat_o.pin_level = pin_r;
  assign stat_o.slot      = slot_r;

endmodule

/* hw/rtl/bps_out_reg.sv */
module bps_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_i,
  input  bps_pkg::res_t res_i,
  output logic          free_o,
  output logic          out_valid,
  input  logic          out_ready,
  output bps_pkg::res_t res_o
);

  logic          vld_r;
  logic          vld_nxt;
  bps_pkg::res_t res_r;

  assign free_o  = !vld_r || out_ready;
  assign vld_nxt = load_i || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid = vld_r;
  assign res_o     = res_r;

endmodule

/* test/tb_beep_pattern_sequencer_top.sv */
`timescale 1ns / 100ps

module tb_beep_pattern_sequencer_top;
  import bps_pkg::*;

  localparam int unsigned SLOTS = PULSE_SLOTS_DEF;

  // Stall patterns of the result side
  typedef enum int unsigned {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_SPARSE
  } sink_mode_t;

  // Tracks the sequencer in step with the accepted requests and holds the
  // pin and busy levels that each request must produce, oldest first.
  class beep_scoreboard;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] last_toggle;
    bit                active;
    bit                cycle_done;
    bit                tone_on;
    bit                pin_level;
    logic [SLOT_W-1:0] slot;
    logic [MS_W-1:0]   pulse_ms [MAX_SLOTS];
    logic [MS_W-1:0]   gap_ms;
    logic [MS_W-1:0]   end_ms;
    res_t              expected_levels [$];
    int unsigned       errors;
    int unsigned       results_checked;
    int unsigned       ticks;
    int unsigned       starts_loaded;
    int unsigned       starts_ignored;

    function new();
      now_ms          = '0;
      last_toggle     = '0;
      active          = 1'b0;
      cycle_done      = 1'b0;
      tone_on         = 1'b0;
      pin_level       = 1'b0;
      slot            = '0;
      gap_ms          = '0;
      end_ms          = '0;
      errors          = 0;
      results_checked = 0;
      ticks           = 0;
      starts_loaded   = 0;
      starts_ignored  = 0;
      for (int i = 0; i < MAX_SLOTS; i++) pulse_ms[i] = '0;
    endfunction

    function void silence();
      if (tone_on) pin_level = 1'b0;
    endfunction

    function logic [MS_W-1:0] slot_length();
      if (slot < SLOT_W'(SLOTS)) return pulse_ms[slot];
      return end_ms;
    endfunction

    function void drive_slot(logic [MS_W-1:0] len);
      logic [TIME_W-1:0] gap_ext;
      logic [TIME_W-1:0] len_ext;
      logic [TIME_W-1:0] gap_end;
      logic [TIME_W-1:0] pulse_end;
      gap_ext   = TIME_W'(gap_ms);
      len_ext   = TIME_W'(len);
      gap_end   = last_toggle + gap_ext;
      pulse_end = last_toggle + len_ext;
      if (!tone_on && now_ms >= gap_end && len != '0) begin
        tone_on     = 1'b1;
        pin_level   = 1'b1;
        last_toggle = now_ms;
      end else if (tone_on && (len == '0 || now_ms >= pulse_end)) begin
        tone_on     = 1'b0;
        cycle_done  = 1'b1;
        pin_level   = 1'b0;
        last_toggle = now_ms;
      end
    endfunction

    // One evaluation of the sequencer at the current time
    function void advance_sequencer();
      logic [MS_W-1:0]   len;
      logic [TIME_W-1:0] pause_ext;
      logic [TIME_W-1:0] pause_edge;
      if (!active) begin
        silence();
        return;
      end
      pause_ext  = TIME_W'(end_ms);
      pause_edge = now_ms - pause_ext;
      if (slot < SLOT_W'(SLOTS)) begin
        len = pulse_ms[slot];
        if (len != '0) drive_slot(len);
      end else if (last_toggle < pause_edge) begin
        slot   = '0;
        active = 1'b0;
        silence();
        return;
      end
      if (cycle_done || slot_length() == '0) begin
        if (slot < SLOT_W'(SLOTS)) slot++;
        cycle_done = 1'b0;
        silence();
      end
    endfunction

    function void note_request(item_t req);
      res_t lv;
      if (req.action == ACT_TICK) begin
        now_ms++;
        ticks++;
        advance_sequencer();
      end else if (!active) begin
        active      = 1'b1;
        pulse_ms[0] = req.first_ms;
        pulse_ms[1] = req.second_ms;
        pulse_ms[2] = req.third_ms;
        gap_ms      = req.gap_ms;
        end_ms      = req.end_ms;
        starts_loaded++;
        advance_sequencer();
      end else begin
        starts_ignored++;
      end
      lv.sound_pin = pin_level;
      lv.busy_res  = active;
      expected_levels.push_back(lv);
    endfunction

    function void check_result(logic pin, logic busy);
      res_t want;
      if (expected_levels.size() == 0) begin
        $error("result with no request outstanding: sound_pin %0b busy_res %0b", pin, busy);
        errors++;
        return;
      end
      want = expected_levels.pop_front();
      results_checked++;
      if (pin !== want.sound_pin) begin
        $error("sound_pin: expected %0b, got %0b", want.sound_pin, pin);
        errors++;
      end
      if (busy !== want.busy_res) begin
        $error("busy_res: expected %0b, got %0b", want.busy_res, busy);
        errors++;
      end
    endfunction
  endclass

  logic            clk          = 1'b0;
  logic            rst_n        = 1'b0;
  logic            in_valid     = 1'b0;
  logic            in_ready;
  logic            in_action    = 1'b0;
  logic [MS_W-1:0] in_first_ms  = '0;
  logic [MS_W-1:0] in_second_ms = '0;
  logic [MS_W-1:0] in_third_ms  = '0;
  logic [MS_W-1:0] in_gap_ms    = '0;
  logic [MS_W-1:0] in_end_ms    = '0;
  logic            out_valid;
  logic            out_ready    = 1'b0;
  logic            out_sound_pin;
  logic            out_busy_res;

  beep_scoreboard  sb;
  int unsigned     burst_left = 0;
  bit              hold_done  = 1'b0;

  beep_pattern_sequencer_top #(
    .PULSE_SLOTS (SLOTS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_first_ms   (in_first_ms),
    .in_second_ms  (in_second_ms),
    .in_third_ms   (in_third_ms),
    .in_gap_ms     (in_gap_ms),
    .in_end_ms     (in_end_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sound_pin (out_sound_pin),
    .out_busy_res  (out_busy_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic item_t make_item(input action_t act,
                                      input logic [MS_W-1:0] f, s, t, g, e);
    item_t it;
    it.action    = act;
    it.first_ms  = f;
    it.second_ms = s;
    it.third_ms  = t;
    it.gap_ms    = g;
    it.end_ms    = e;
    return it;
  endfunction

  // Random content in every field; a tick ignores the lengths, a start
  // while busy ignores everything, so both toggle every bit cheaply.
  function automatic item_t random_item(input action_t act);
    return make_item(act, MS_W'($urandom), MS_W'($urandom), MS_W'($urandom),
                     MS_W'($urandom), MS_W'($urandom));
  endfunction

  // Offer one request and hold it until accepted. The sender works in bursts:
  // at the end of each burst drop valid for a random gap, or go straight on.
  task automatic send_request(input item_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_action    <= req.action;
    in_first_ms  <= req.first_ms;
    in_second_ms <= req.second_ms;
    in_third_ms  <= req.third_ms;
    in_gap_ms    <= req.gap_ms;
    in_end_ms    <= req.end_ms;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  // Tick until the sequence has ended; with noise, slip in starts that the
  // busy sequencer must ignore.
  task automatic run_until_idle(input bit noisy);
    int unsigned guard;
    guard = 0;
    while (sb.active && guard < 20000) begin
      if (noisy && $urandom_range(0, 19) == 0) send_request(random_item(ACT_START));
      else send_request(random_item(ACT_TICK));
      guard++;
    end
  endtask

  task automatic play_sequence(input logic [MS_W-1:0] f, s, t, g, e, input bit noisy);
    send_request(make_item(ACT_START, f, s, t, g, e));
    run_until_idle(noisy);
  endtask

  // Well-formed sequence with random content: short pulses mostly, now and
  // then a long one, and skipped slots about a quarter of the time.
  task automatic play_random_sequence();
    logic [MS_W-1:0] len [MAX_SLOTS];
    logic [MS_W-1:0] gap;
    logic [MS_W-1:0] pause;
    bit              any_pulse;
    int unsigned     pick;
    any_pulse = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      pick = $urandom_range(0, 39);
      if (pick < 10) len[i] = '0;
      else if (pick == 39) len[i] = MS_W'($urandom_range(100, 400));
      else len[i] = MS_W'($urandom_range(1, 6));
      if (len[i] != '0) any_pulse = 1'b1;
    end
    // a long gap only costs time when some pulse has to wait for it
    if (!any_pulse) gap = MS_W'($urandom);
    else if ($urandom_range(0, 29) == 0) gap = MS_W'($urandom_range(20, 200));
    else gap = MS_W'($urandom_range(0, 4));
    // a pause beyond the current time wraps the end test and ends at once
    pause = ($urandom_range(0, 1) == 0) ? MS_W'($urandom_range(0, 8)) : MS_W'($urandom);
    play_sequence(len[0], len[1], len[2], gap, pause, 1'b1);
  endtask

  // Accept results at the sampled handshake and check them in order
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_sound_pin, out_busy_res);
  end

  // Result side: random stretches of open, random and sparse readiness,
  // plus one long hold-off so that the block backs up and stalls its input.
  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned stretch;
    int unsigned phase;
    int unsigned wait_cnt;
    phase = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!hold_done && sb.results_checked >= 300) begin
        out_ready <= 1'b0;
        wait_cnt = 0;
        while (wait_cnt < 400) begin
          @(posedge clk);
          wait_cnt++;
        end
        hold_done = 1'b1;
      end
      mode    = sink_mode_t'($urandom_range(0, 2));
      stretch = $urandom_range(4, 40);
      repeat (stretch) begin
        case (mode)
          SINK_OPEN: begin
            out_ready <= 1'b1;
          end
          SINK_RANDOM: begin
            out_ready <= ($urandom_range(0, 9) < 7);
          end
          default: begin
            out_ready <= (phase % 3 == 0);
          end
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned drain;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Tick while idle: time advances, pin stays low
    send_request(random_item(ACT_TICK));
    // All slots skipped and the longest pause: now - pause wraps, so the
    // sequence ends as soon as it is past the last slot
    play_sequence(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0);
    // Start while idle drives the pin at once; the middle slot is skipped
    play_sequence(16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 1'b0);
    // A start while idle loads; the starts after it, with all ones and all zeros, come while busy and must be dropped
    send_request(make_item(ACT_START, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2));
    send_request(make_item(ACT_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_item(ACT_START, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    run_until_idle(1'b0);
    // Longest gap with nothing to play, and no end pause
    play_sequence(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b0);

    while (sb.ticks + sb.starts_loaded < 1350) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_request(random_item(ACT_TICK));
      end else begin
        play_random_sequence();
      end
    end
    in_valid <= 1'b0;

    // Drain the pipeline, then keep waiting for stray results
    drain = 0;
    while (sb.expected_levels.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (sb.expected_levels.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_levels.size());
      sb.errors++;
    end

    $display("Run covered %0d ticks, %0d loaded starts and %0d starts dropped while busy;",
             sb.ticks, sb.starts_loaded, sb.starts_ignored);
    $display("%0d results checked, long result hold-off %s.", sb.results_checked,
             hold_done ? "applied" : "not reached");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
